FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/core/ica_pkg.sv
// Package: constants, arctangent table, control structs of the attitude core
`timescale 1ns / 1ps
package ica_pkg;
  localparam int AngW = 40;
  localparam int CordW = 36;  // 16-bit operand scaled by 2^16 plus growth
  localparam int ZW = 34;
  localparam logic signed [ZW-1:0] Deg180 = 34'sd3019898880;
  localparam logic signed [AngW-1:0] AngMax = {1'b0, {(AngW-1){1'b1}}};
  localparam logic signed [AngW-1:0] AngMin = {1'b1, {(AngW-1){1'b0}}};

  typedef enum logic [2:0] {
    RegGxOff = 3'd0, RegGyOff = 3'd1, RegGzOff = 3'd2,
    RegDeadband = 3'd3, RegStepScale = 3'd4, RegWeight = 3'd5
  } reg_idx_e;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OpNone    = 3'd0,
    OpLoad    = 3'd1,  // capture sample, fix gyros
    OpCordInit = 3'd2, // set up CORDIC for the selected axis
    OpCordStep = 3'd3,
    OpCordDone = 3'd4, // store accel angle
    OpMul     = 3'd5,  // gyro step product for the selected axis
    OpBlend   = 3'd6,  // predict the selected axis and form the accel difference
    OpBlend2  = 3'd7
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] axis;  // 0 roll, 1 pitch, 2 yaw
  } dp_cmd_t;

  typedef struct packed {
    logic cord_last;
  } dp_sts_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0: r = 34'sd754974720;  5'd1: r = 34'sd445687602;
      5'd2: r = 34'sd235489088;  5'd3: r = 34'sd119537938;
      5'd4: r = 34'sd60000934;   5'd5: r = 34'sd30029717;
      5'd6: r = 34'sd15018523;   5'd7: r = 34'sd7509720;
      5'd8: r = 34'sd3754917;    5'd9: r = 34'sd1877466;
      5'd10: r = 34'sd938734;    5'd11: r = 34'sd469367;
      5'd12: r = 34'sd234684;    5'd13: r = 34'sd117342;
      5'd14: r = 34'sd58671;     5'd15: r = 34'sd29335;
      5'd16: r = 34'sd14668;     5'd17: r = 34'sd7334;
      5'd18: r = 34'sd3667;      5'd19: r = 34'sd1833;
      5'd20: r = 34'sd917;       5'd21: r = 34'sd458;
      5'd22: r = 34'sd229;       5'd23: r = 34'sd115;
      5'd24: r = 34'sd57;        5'd25: r = 34'sd29;
      5'd26: r = 34'sd14;        5'd27: r = 34'sd7;
      5'd28: r = 34'sd4;         5'd29: r = 34'sd2;
      5'd30: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

FILE: rtl/core/ica_ctrl.sv
// Controller: sequences load, two CORDIC runs, products and blends
`timescale 1ns / 1ps
module ica_ctrl #(
  parameter int CordicSteps = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ica_pkg::dp_sts_t sts_i,
  output ica_pkg::dp_cmd_t cmd_o,
  output logic [4:0]       step_o
);
  import ica_pkg::*;
  localparam int NSteps = (CordicSteps > 32) ? 32 : CordicSteps;

  typedef enum logic [7:0] {
    SIdle  = 8'b00000001,
    SInit  = 8'b00000010,
    SStep  = 8'b00000100,
    SDone  = 8'b00001000,
    SMul   = 8'b00010000,
    SBlend = 8'b00100000,
    SBl2   = 8'b01000000,
    SOut   = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [4:0] step_q, step_d;
  logic accepted;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign accepted    = in_valid_i && in_ready_o;
  assign step_o      = step_q;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    step_d  = step_q;
    cmd_o.op   = OpNone;
    cmd_o.axis = axis_q;
    case (state_q)
      SIdle: begin
        if (accepted) begin
          cmd_o.op = OpLoad;
          axis_d = 2'd0;
          state_d = SInit;
        end
      end
      SInit: begin
        cmd_o.op = OpCordInit;
        step_d = '0;
        state_d = SStep;
      end
      SStep: begin
        cmd_o.op = OpCordStep;
        step_d = step_q + 5'd1;
        if (step_q == 5'(NSteps - 1)) state_d = SDone;
      end
      SDone: begin
        cmd_o.op = OpCordDone;
        if (axis_q == 2'd0) begin
          axis_d = 2'd1;
          state_d = SInit;
        end else begin
          axis_d = 2'd0;
          state_d = SMul;
        end
      end
      SMul: begin
        cmd_o.op = OpMul;
        state_d = SBlend;
      end
      SBlend: begin
        cmd_o.op = OpBlend;
        state_d = SBl2;
      end
      SBl2: begin
        cmd_o.op = OpBlend2;
        if (axis_q == 2'd2) state_d = SOut;
        else begin
          axis_d = axis_q + 2'd1;
          state_d = SMul;
        end
      end
      SOut: begin
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      axis_q  <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      step_q  <= step_d;
    end
  end

  logic unused_sts;
  assign unused_sts = sts_i.cord_last;
endmodule

FILE: rtl/core/ica_dpath.sv
// Datapath: gyro correction, shared CORDIC, multiplier, blend and angle state
`timescale 1ns / 1ps
module ica_dpath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [31:0]            cfg_data_i,
  input  logic [95:0]            sample_i,
  input  ica_pkg::dp_cmd_t       cmd_i,
  input  logic [4:0]             step_i,
  output ica_pkg::dp_sts_t       sts_o,
  output logic signed [39:0]     pitch_o,
  output logic signed [39:0]     roll_o,
  output logic signed [39:0]     yaw_o
);
  import ica_pkg::*;

  logic signed [15:0] offx_q, offy_q, offz_q;
  logic [14:0] dead_q;
  logic [31:0] scale_q;
  logic [24:0] weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offx_q <= 16'sd10;
      offy_q <= -16'sd8;
      offz_q <= 16'sd38;
      dead_q <= 15'd2;
      scale_q <= 32'd340787;
      weight_q <= 25'd16777;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegGxOff:     offx_q <= cfg_data_i[15:0];
        RegGyOff:     offy_q <= cfg_data_i[15:0];
        RegGzOff:     offz_q <= cfg_data_i[15:0];
        RegDeadband:  dead_q <= cfg_data_i[14:0];
        RegStepScale: scale_q <= cfg_data_i;
        RegWeight:    weight_q <= cfg_data_i[24:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [15:0] gfix(input logic signed [15:0] r,
                                              input logic signed [15:0] o,
                                              input logic [14:0] db);
    logic signed [16:0] s;
    logic signed [15:0] g;
    logic [15:0] mag;
    s = 17'(r) + 17'(o);
    if (s > 17'sd32767) g = 16'sd32767;
    else if (s < -17'sd32768) g = -16'sd32768;
    else g = s[15:0];
    mag = g[15] ? 16'(-g) : g;
    if (mag < {1'b0, db}) g = '0;
    return g;
  endfunction

  logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
  logic signed [CordW-1:0] cx_q, cy_q;
  logic signed [ZW-1:0] cz_q;
  logic signed [AngW-1:0] roll_acc_q, pitch_acc_q;
  logic signed [AngW-1:0] roll_q, pitch_q, yaw_q;
  logic signed [48:0] prod_q;
  logic signed [AngW-1:0] pred_q;
  logic signed [AngW:0] diff_q;

  // CORDIC set-up for the selected axis
  logic signed [15:0] ysel;
  logic signed [CordW-1:0] xs, ys, cx_i, cy_i;
  logic signed [ZW-1:0] cz_i;
  always_comb begin
    ysel = (cmd_i.axis == 2'd0) ? ay_q : ax_q;
    cx_i = {{(CordW-32){az_q[15]}}, az_q, 16'h0};
    cy_i = {{(CordW-32){ysel[15]}}, ysel, 16'h0};
    cz_i = '0;
    if (az_q < 0) begin
      cz_i = (ysel >= 0) ? Deg180 : -Deg180;
      cx_i = -cx_i;
      cy_i = -cy_i;
    end
    xs = cx_q >>> step_i;
    ys = cy_q >>> step_i;
  end

  // gyro step product; the multiplier is shared by the three axes
  logic signed [15:0] gsel;
  logic signed [AngW-1:0] gstate, gacc;
  always_comb begin
    case (cmd_i.axis)
      2'd0: begin gsel = gx_q; gstate = roll_q; gacc = roll_acc_q; end
      2'd1: begin gsel = gy_q; gstate = pitch_q; gacc = pitch_acc_q; end
      default: begin gsel = gz_q; gstate = yaw_q; gacc = '0; end
    endcase
  end

  logic signed [AngW+1:0] psum;
  logic signed [AngW-1:0] psat;
  logic signed [40:0] step_v;
  logic [24:0] w;
  logic signed [AngW-1:0] dh;
  logic [23:0] dl;
  logic signed [AngW+26:0] blended;
  always_comb begin
    step_v = 41'((prod_q + 49'sd128) >>> 8);
    psum = 42'(gstate) + 42'(step_v);
    if (psum > 42'(AngMax)) psat = AngMax;
    else if (psum < 42'(AngMin)) psat = AngMin;
    else psat = psum[AngW-1:0];
    w = (weight_q > 25'd16777216) ? 25'd16777216 : weight_q;
    dh = 40'(diff_q >>> 24);
    dl = diff_q[23:0];
    blended = 67'(pred_q) + 67'(dh) * $signed({1'b0, w})
            + 67'((({25'd0, dl} * {24'd0, w}) + 49'd8388608) >> 24);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_q <= '0;
      pitch_q <= '0;
      yaw_q <= '0;
    end else begin
      case (cmd_i.op)
        OpBlend2: begin
          case (cmd_i.axis)
            2'd0: roll_q <= blended[AngW-1:0];
            2'd1: pitch_q <= blended[AngW-1:0];
            default: yaw_q <= pred_q;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OpLoad: begin
        ax_q <= sample_i[15:0];
        ay_q <= sample_i[31:16];
        az_q <= sample_i[47:32];
        gx_q <= gfix(sample_i[63:48], offx_q, dead_q);
        gy_q <= gfix(sample_i[79:64], offy_q, dead_q);
        gz_q <= gfix(sample_i[95:80], offz_q, dead_q);
      end
      OpCordInit: begin
        cx_q <= cx_i;
        cy_q <= cy_i;
        cz_q <= cz_i;
      end
      OpCordStep: begin
        if (cy_q > 0) begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + atan_lut(step_i);
        end else if (cy_q < 0) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - atan_lut(step_i);
        end
      end
      OpCordDone: begin
        // zero vector gives zero
        if (cmd_i.axis == 2'd0)
          roll_acc_q <= (ay_q == 0 && az_q == 0) ? '0 : 40'(cz_q);
        else
          pitch_acc_q <= (ax_q == 0 && az_q == 0) ? '0 : -40'(cz_q);
      end
      OpMul: prod_q <= 49'(gsel) * $signed({1'b0, scale_q});
      OpBlend: begin
        pred_q <= psat;
        diff_q <= 41'(gacc) - 41'(psat);
      end
      default: ;
    endcase
  end

  assign sts_o.cord_last = (cmd_i.op == OpCordDone);
  assign pitch_o = pitch_q;
  assign roll_o  = roll_q;
  assign yaw_o   = yaw_q;
endmodule

FILE: rtl/core/imu_complementary_attitude_core.sv
// Top level of the six-axis complementary attitude estimator
`timescale 1ns / 1ps
// Usage:
//  s_axis: one six-axis sample per request; tdata holds accel x,y,z then
//  gyro rate x,y,z, 16 bits each, two's complement.
//  m_axis: one result per sample, tdata = pitch, roll, yaw, 40-bit Q.24 deg.
//  cfg: write enable, register index 0..5, 32-bit data; write only while idle.
//  The shared CORDIC unit runs roll then pitch, and the shared multiplier
//  is used once per axis.
//  One sample is in flight at a time; s_axis_tready is high only when idle.
//  Reset clears the angle state to zero and loads the register defaults.
//  A stalled receiver holds the result steady and blocks new samples.
module imu_complementary_attitude_core #(
  parameter int CordicSteps = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata   // pitch_angle, roll_angle, yaw_angle
);
  import ica_pkg::*;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [4:0] step;
  logic signed [39:0] pitch, roll, yaw;

  ica_ctrl #(.CordicSteps(CordicSteps)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd), .step_o(step)
  );

  ica_dpath u_dpath (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .sample_i(s_axis_tdata), .cmd_i(cmd), .step_i(step), .sts_o(sts),
    .pitch_o(pitch), .roll_o(roll), .yaw_o(yaw)
  );

  assign m_axis_tdata = {yaw, roll, pitch};
endmodule

FILE: rtl/core/ica_checker.sv
// Port-level checker for the attitude core, with its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ica_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [119:0] m_axis_tdata
);
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
  `ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready, "sample taken while result pending")
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid, "core not busy after request")
  `ASSERT_NEXT(a_out_done, clk_i, rst_ni, m_axis_tvalid && m_axis_tready, s_axis_tready && !m_axis_tvalid, "core not idle after result")
endmodule

bind imu_complementary_attitude_core ica_checker u_ica_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

FILE: tb/testbench.sv
// Self-checking testbench for the complementary attitude core
`timescale 1ns / 1ps
module testbench;
  import ica_pkg::*;

  localparam int      NSteps   = 24;
  localparam int      DoneWait = 2 * (NSteps + 2) + 20;
  localparam longint  CycleCap = 600000;
  localparam longint  AMax     = 64'sd549755813887;
  localparam longint  AMin     = -64'sd549755813888;
  localparam longint  OneQ24   = 64'sd16777216;
  localparam longint  HalfTurn = 64'sd3019898880;
  localparam longint  AtanQ24 [32] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0};

  typedef struct packed {
    logic [39:0] yaw;
    logic [39:0] roll;
    logic [39:0] pitch;
  } attitude_t;

  typedef struct {
    shortint ax, ay, az, rx, ry, rz;
    bit      typed;
    longint  pitch, roll, yaw;
  } sample_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  reg_idx_e     cfg_idx_i = RegGxOff;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;

  // typed-in expectation travels beside the request
  logic         row_typed = 1'b0;
  attitude_t    row_attitude = '0;

  bit           calm = 1'b0;   // no idling on either side
  int           errors = 0;
  longint       cycles = 0;
  int           n_sent = 0;
  int           n_got = 0;
  attitude_t    pending_q[$];

  // predictor state and register copies
  longint       off_x, off_y, off_z, deadband, step_scale, weight;
  longint       roll_s, pitch_s, yaw_s;

  always #5 clk_i = ~clk_i;

  imu_complementary_attitude_core #(.CordicSteps(NSteps)) DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  function automatic longint sat_angle(longint v);
    return (v > AMax) ? AMax : (v < AMin) ? AMin : v;
  endfunction

  function automatic longint fix_rate(shortint raw, longint off);
    longint g;
    g = longint'(raw) + off;
    if (g > 32767) g = 32767;
    if (g < -32768) g = -32768;
    if (((g < 0) ? -g : g) < deadband) g = 0;
    return g;
  endfunction

  function automatic longint arctan2_deg(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 65536;
    y = y * 65536;
    if (x < 0) begin
      z = (y >= 0) ? HalfTurn : -HalfTurn;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < NSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += AtanQ24[i];
      end else if (y < 0) begin
        x -= ys; y += xs; z -= AtanQ24[i];
      end
    end
    return z;
  endfunction

  function automatic longint rate_step(longint g);
    return (g * step_scale + 128) >>> 8;
  endfunction

  function automatic longint fuse(longint acc, longint g);
    longint w, d, dh, dl;
    w = (weight > OneQ24) ? OneQ24 : weight;
    d = acc - g;
    dh = d >>> 24;
    dl = d & 64'hFF_FFFF;
    return g + w * dh + ((w * dl + (OneQ24 >>> 1)) >>> 24);
  endfunction

  // advances the attitude state by one sample
  function automatic attitude_t track_attitude(logic [95:0] d);
    shortint ax, ay, az;
    longint gx, gy, gz;
    attitude_t r;
    ax = d[15:0]; ay = d[31:16]; az = d[47:32];
    gx = fix_rate(d[63:48], off_x);
    gy = fix_rate(d[79:64], off_y);
    gz = fix_rate(d[95:80], off_z);
    roll_s  = fuse(arctan2_deg(ay, az), sat_angle(roll_s + rate_step(gx)));
    pitch_s = fuse(-arctan2_deg(ax, az), sat_angle(pitch_s + rate_step(gy)));
    yaw_s   = sat_angle(yaw_s + rate_step(gz));
    r.pitch = pitch_s[39:0];
    r.roll  = roll_s[39:0];
    r.yaw   = yaw_s[39:0];
    return r;
  endfunction

  task automatic report(string what, logic [39:0] got, logic [39:0] want);
    $display("MISMATCH result %0d %s: got %0d want %0d", n_got, what,
             $signed(got), $signed(want));
    errors++;
  endtask

  // register copies, predictor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    attitude_t got, want, typed_val;
    if (!rst_ni) begin
      off_x = 10; off_y = -8; off_z = 38; deadband = 2;
      step_scale = 340787; weight = 16777;
      roll_s = 0; pitch_s = 0; yaw_s = 0;
    end else begin
      cycles++;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegGxOff:     off_x = longint'($signed(cfg_data_i[15:0]));
          RegGyOff:     off_y = longint'($signed(cfg_data_i[15:0]));
          RegGzOff:     off_z = longint'($signed(cfg_data_i[15:0]));
          RegDeadband:  deadband = cfg_data_i[14:0];
          RegStepScale: step_scale = cfg_data_i;
          RegWeight:    weight = cfg_data_i[24:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        typed_val = track_attitude(s_axis_tdata);
        // yaw carries over from earlier samples, so it stays predicted
        if (row_typed) begin
          typed_val.pitch = row_attitude.pitch;
          typed_val.roll  = row_attitude.roll;
        end
        pending_q.push_back(typed_val);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_q.size() == 0) begin
          $display("UNEXPECTED result %0d", n_got);
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (got.pitch !== want.pitch) report("pitch", got.pitch, want.pitch);
          if (got.roll !== want.roll) report("roll", got.roll, want.roll);
          if (got.yaw !== want.yaw) report("yaw", got.yaw, want.yaw);
        end
        n_got++;
      end
    end
  end

  always @(posedge clk_i)
    m_axis_tready <= calm || ($urandom_range(99) >= 19);

  always @(posedge clk_i)
    if (cycles > CycleCap) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    row_typed <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DoneWait) @(posedge clk_i);
  endtask

  task automatic load_regs(shortint ox, shortint oy, shortint oz, int db,
                           logic [31:0] sc, logic [24:0] w);
    drain();
    write_reg(RegGxOff, 32'(ox));
    write_reg(RegGyOff, 32'(oy));
    write_reg(RegGzOff, 32'(oz));
    write_reg(RegDeadband, 32'(db));
    write_reg(RegStepScale, sc);
    write_reg(RegWeight, 32'(w));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send(sample_row_t r);
    attitude_t t;
    t.pitch = r.pitch[39:0];
    t.roll  = r.roll[39:0];
    t.yaw   = r.yaw[39:0];
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r.rz, r.ry, r.rx, r.az, r.ay, r.ax};
    row_typed <= r.typed;
    row_attitude <= t;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    if (!calm && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  function automatic shortint pick_field(bit near_zero);
    int k;
    k = $urandom_range(99);
    if (k < 12) begin
      case ($urandom_range(4))
        0: return -32768;
        1: return 32767;
        2: return 0;
        3: return -1;
        default: return 1;
      endcase
    end
    if (k < 30 || near_zero) return shortint'(int'($urandom_range(400)) - 200);
    return shortint'($urandom());
  endfunction

  task automatic random_run(int count);
    sample_row_t r;
    for (int i = 0; i < count; i++) begin
      r.ax = pick_field(0); r.ay = pick_field(0); r.az = pick_field(0);
      r.rx = pick_field(0); r.ry = pick_field(0); r.rz = pick_field(0);
      r.typed = 1'b0;
      r.pitch = 0; r.roll = 0; r.yaw = 0;
      if ($urandom_range(9) == 0) begin
        // near-flat attitude: small accel cross axes
        r.ax = pick_field(1); r.ay = pick_field(1);
      end
      send(r);
      if ($urandom_range(49) == 0) drain();
    end
  endtask

  sample_row_t rows[$];

  initial begin
    rows = '{
      '{0, 0, 100, 0, 0, 0, 1, 0, 0, 0},
      '{0, 0, -100, 0, 0, 0, 1, -HalfTurn, HalfTurn, 0},
      '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{32767, 0, 1, 0, 0, 0, 0, 0, 0, 0},
      '{-32768, -32768, -32768, 0, 0, 0, 0, 0, 0, 0},
      '{0, 32767, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, -32768, 0, 0, 0, 0, 0, 0, 0, 0},
      '{-32768, 32767, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, -1, -32768, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 32767, 32767, 32767, 32767, 0, 0, 0, 0},
      '{0, 0, 32767, 32767, 32767, 32767, 0, 0, 0, 0},
      '{0, 0, 32767, -32768, -32768, -32768, 0, 0, 0, 0},
      '{0, 0, 32767, -32768, -32768, -32768, 0, 0, 0, 0},
      '{0, 0, 32767, -32768, -32768, -32768, 0, 0, 0, 0},
      '{100, 100, 100, 1, -1, 2, 0, 0, 0, 0},
      '{-100, 100, -100, -2, 3, -3, 0, 0, 0, 0},
      '{12345, -23456, 3456, 99, -99, 100, 0, 0, 0, 0},
      '{-1, -1, -1, -1, -1, -1, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    random_run(80);  // register defaults

    // pure accelerometer, no rate: roll and pitch read off directly
    load_regs(0, 0, 0, 0, 32'd0, 25'd16777216);
    foreach (rows[i]) send(rows[i]);
    // rate extremes with weight above one and full-scale step
    load_regs(32767, -32768, 32767, 100, 32'hFFFF_FFFF, 25'h1FF_FFFF);
    foreach (rows[i]) begin
      rows[i].typed = 1'b0;
      send(rows[i]);
    end

    // gyro only: saturation of every angle
    load_regs(-32768, -32768, -32768, 0, 32'hFFFF_FFFF, 25'd0);
    random_run(80);
    load_regs(32767, 32767, 32767, 32767, 32'd0, 25'd16777216);
    random_run(60);
    for (int p = 0; p < 7; p++) begin
      load_regs(shortint'(int'($urandom_range(400)) - 200),
                shortint'(int'($urandom_range(400)) - 200),
                shortint'($urandom()), $urandom_range(300),
                (p % 2) ? $urandom() : 32'($urandom_range(2000000)),
                25'($urandom_range(17000000)));
      calm = (p == 3);
      random_run(100);
      calm = 1'b0;
    end
    drain();

    $display("Sent %0d samples, checked %0d results over 12 register settings,",
             n_sent, n_got);
    $display("including zero and full weight, rate extremes and angle saturation.");
    if (errors == 0 && pending_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ica_pkg.sv
rtl/core/ica_ctrl.sv
rtl/core/ica_dpath.sv
rtl/core/imu_complementary_attitude_core.sv
rtl/core/ica_checker.sv
tb/testbench.sv
